[src/ce0ff_pkg.sv]
// Package with opcode codes, access kinds and the result word type of the E0..FF execute unit.
package ce0ff_pkg;

  typedef logic [4:0] cmd_t;
  typedef logic [1:0] kind_t;

  // Memory access kinds.
  localparam kind_t KIND_NONE = 2'd0;
  localparam kind_t KIND_BYTE = 2'd1;
  localparam kind_t KIND_WORD = 2'd2;

  // Opcode minus 0xE0.
  localparam cmd_t CMD_LDH_N_A  = 5'h00;
  localparam cmd_t CMD_POP_HL   = 5'h01;
  localparam cmd_t CMD_LD_C_A   = 5'h02;
  localparam cmd_t CMD_PUSH_HL  = 5'h05;
  localparam cmd_t CMD_AND_N    = 5'h06;
  localparam cmd_t CMD_RST20    = 5'h07;
  localparam cmd_t CMD_ADD_SP   = 5'h08;
  localparam cmd_t CMD_JP_HL    = 5'h09;
  localparam cmd_t CMD_LD_NN_A  = 5'h0A;
  localparam cmd_t CMD_XOR_N    = 5'h0E;
  localparam cmd_t CMD_RST28    = 5'h0F;
  localparam cmd_t CMD_LDH_A_N  = 5'h10;
  localparam cmd_t CMD_POP_AF   = 5'h11;
  localparam cmd_t CMD_LD_A_C   = 5'h12;
  localparam cmd_t CMD_DI       = 5'h13;
  localparam cmd_t CMD_PUSH_AF  = 5'h15;
  localparam cmd_t CMD_OR_N     = 5'h16;
  localparam cmd_t CMD_RST30    = 5'h17;
  localparam cmd_t CMD_LD_HL_SP = 5'h18;
  localparam cmd_t CMD_LD_SP_HL = 5'h19;
  localparam cmd_t CMD_LD_A_NN  = 5'h1A;
  localparam cmd_t CMD_EI       = 5'h1B;
  localparam cmd_t CMD_CP_N     = 5'h1E;
  localparam cmd_t CMD_RST38    = 5'h1F;

  // Flag nibble bit positions: Z, N, H, C.
  localparam logic [3:0] FLAG_Z = 4'b1000;
  localparam logic [3:0] FLAG_N = 4'b0100;
  localparam logic [3:0] FLAG_H = 4'b0010;
  localparam logic [3:0] FLAG_C = 4'b0001;

  localparam logic [7:0]  HIGH_PAGE = 8'hFF;
  localparam logic [15:0] RST_BASE  = 16'h0020;

  typedef struct packed {
    kind_t       write_kind;
    logic [15:0] write_addr;
    logic [15:0] write_data;
    kind_t       read_kind;
    logic [15:0] read_addr;
    logic [15:0] pc;
    logic [15:0] sp;
    logic [7:0]  acc;
    logic [3:0]  flags;
    logic [15:0] hl;
    logic        ime;
    logic        illegal;
  } res_t;

endpackage

[src/cpu_opcode_e0_ff_execute_unit.sv]
// Execute unit for opcodes 0xE0 to 0xFF of an 8-bit SM83-style CPU.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------------------
//   in_     | input     | in_valid / in_stall | cmd, imm_bytes, load_data, reg_c
//   out_    | output    | out_valid/out_stall | write/read access, pc, sp, acc, flags,
//           |           |                     | hl, ime, illegal
//
// One word is accepted per cycle while in_stall is low. The input stage captures the taken word;
// once the result register is free, the word executes against the register state and the result
// register captures the result. The execute step is a single pass of adders and muxes.
// Reset clears A, the flags, HL, SP, PC, IME and both valid flags.
// A stalled output holds its result; the input stage then fills and in_stall rises.
module cpu_opcode_e0_ff_execute_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ce0ff_pkg::cmd_t      in_cmd,
  input  logic [15:0]          in_imm_bytes,
  input  logic [15:0]          in_load_data,
  input  logic [7:0]           in_reg_c,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ce0ff_pkg::kind_t     out_write_kind,
  output logic [15:0]          out_write_addr,
  output logic [15:0]          out_write_data,
  output ce0ff_pkg::kind_t     out_read_kind,
  output logic [15:0]          out_read_addr,
  output logic [15:0]          out_pc,
  output logic [15:0]          out_sp,
  output logic [7:0]           out_acc,
  output logic [7:0]           out_flags,
  output logic [15:0]          out_hl,
  output logic                 out_ime,
  output logic                 out_illegal
);
  import ce0ff_pkg::*;

  // Input stage registers.
  logic        s1_valid_r;
  cmd_t        s1_cmd_r;
  logic [15:0] s1_imm_r;
  logic [15:0] s1_load_r;
  logic [7:0]  s1_c_r;

  // Architectural state.
  logic [7:0]  acc_r,   acc_nxt;
  logic [3:0]  flags_r, flags_nxt;
  logic [15:0] hl_r,    hl_nxt;
  logic [15:0] sp_r,    sp_nxt;
  logic [15:0] pc_r,    pc_nxt;
  logic        ime_r,   ime_nxt;

  // Result register.
  logic        out_valid_r;
  res_t        res_r, res_nxt;

  logic        out_free;
  logic        exec_go;
  logic        in_take;

  // The result register can load when it is empty or its word is leaving now.
  assign out_free = !out_valid_r || !out_stall;
  assign exec_go  = s1_valid_r && out_free;
  // The input stage can load when empty or when its word moves on this edge.
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  // Shared arithmetic for the signed-offset instructions and the logic and compare operations.
  logic [7:0]  imm_lo;
  logic [15:0] sp_off;
  logic [4:0]  nib_sum;
  logic [8:0]  byte_sum;
  logic [3:0]  off_flags;
  logic [7:0]  alu_and, alu_xor, alu_or, cp_diff;
  logic [3:0]  cp_flags;

  assign imm_lo    = s1_imm_r[7:0];
  assign sp_off    = sp_r + {{8{imm_lo[7]}}, imm_lo};
  assign nib_sum   = {1'b0, sp_r[3:0]} + {1'b0, imm_lo[3:0]};
  assign byte_sum  = {1'b0, sp_r[7:0]} + {1'b0, imm_lo};
  // Z and N clear; H and C are the unsigned carries out of bits 3 and 7.
  assign off_flags = (nib_sum[4] ? FLAG_H : 4'b0) | (byte_sum[8] ? FLAG_C : 4'b0);

  assign alu_and = acc_r & imm_lo;
  assign alu_xor = acc_r ^ imm_lo;
  assign alu_or  = acc_r | imm_lo;
  assign cp_diff = acc_r - imm_lo;
  assign cp_flags = FLAG_N
                  | ((cp_diff == 8'h00) ? FLAG_Z : 4'b0)
                  | ((imm_lo[3:0] > acc_r[3:0]) ? FLAG_H : 4'b0)
                  | ((imm_lo > acc_r) ? FLAG_C : 4'b0);

  always_comb begin
    logic        ill;
    kind_t       wk, rk;
    logic [15:0] wa, wd, ra;

    ill = 1'b0;
    wk  = KIND_NONE;
    rk  = KIND_NONE;
    wa  = 16'h0000;
    wd  = 16'h0000;
    ra  = 16'h0000;

    acc_nxt   = acc_r;
    flags_nxt = flags_r;
    hl_nxt    = hl_r;
    sp_nxt    = sp_r;
    pc_nxt    = pc_r;
    ime_nxt   = ime_r;

    unique case (s1_cmd_r) inside
      CMD_LDH_N_A: begin
        wk = KIND_BYTE; wa = {HIGH_PAGE, imm_lo}; wd = {8'h00, acc_r};
        pc_nxt = pc_r + 16'd2;
      end
      CMD_POP_HL: begin
        rk = KIND_WORD; ra = sp_r; hl_nxt = s1_load_r;
        sp_nxt = sp_r + 16'd2; pc_nxt = pc_r + 16'd1;
      end
      CMD_LD_C_A: begin
        wk = KIND_BYTE; wa = {HIGH_PAGE, s1_c_r}; wd = {8'h00, acc_r};
        pc_nxt = pc_r + 16'd1;
      end
      CMD_PUSH_HL: begin
        sp_nxt = sp_r - 16'd2;
        wk = KIND_WORD; wa = sp_r - 16'd2; wd = hl_r;
        pc_nxt = pc_r + 16'd1;
      end
      CMD_AND_N: begin
        acc_nxt   = alu_and;
        flags_nxt = ((alu_and == 8'h00) ? FLAG_Z : 4'b0) | FLAG_H;
        pc_nxt    = pc_r + 16'd2;
      end
      CMD_ADD_SP: begin
        sp_nxt = sp_off; flags_nxt = off_flags; pc_nxt = pc_r + 16'd2;
      end
      CMD_JP_HL: begin
        pc_nxt = hl_r;
      end
      CMD_LD_NN_A: begin
        wk = KIND_BYTE; wa = s1_imm_r; wd = {8'h00, acc_r};
        pc_nxt = pc_r + 16'd3;
      end
      CMD_XOR_N: begin
        acc_nxt   = alu_xor;
        flags_nxt = (alu_xor == 8'h00) ? FLAG_Z : 4'b0;
        pc_nxt    = pc_r + 16'd2;
      end
      CMD_LDH_A_N: begin
        rk = KIND_BYTE; ra = {HIGH_PAGE, imm_lo}; acc_nxt = s1_load_r[7:0];
        pc_nxt = pc_r + 16'd2;
      end
      CMD_POP_AF: begin
        rk = KIND_WORD; ra = sp_r;
        flags_nxt = s1_load_r[7:4]; acc_nxt = s1_load_r[15:8];
        sp_nxt = sp_r + 16'd2; pc_nxt = pc_r + 16'd1;
      end
      CMD_LD_A_C: begin
        rk = KIND_BYTE; ra = {HIGH_PAGE, s1_c_r}; acc_nxt = s1_load_r[7:0];
        pc_nxt = pc_r + 16'd1;
      end
      CMD_DI: begin
        ime_nxt = 1'b0; pc_nxt = pc_r + 16'd1;
      end
      CMD_PUSH_AF: begin
        sp_nxt = sp_r - 16'd2;
        wk = KIND_WORD; wa = sp_r - 16'd2; wd = {acc_r, flags_r, 4'h0};
        pc_nxt = pc_r + 16'd1;
      end
      CMD_OR_N: begin
        acc_nxt   = alu_or;
        flags_nxt = (alu_or == 8'h00) ? FLAG_Z : 4'b0;
        pc_nxt    = pc_r + 16'd2;
      end
      CMD_LD_HL_SP: begin
        hl_nxt = sp_off; flags_nxt = off_flags; pc_nxt = pc_r + 16'd2;
      end
      CMD_LD_SP_HL: begin
        sp_nxt = hl_r; pc_nxt = pc_r + 16'd1;
      end
      CMD_LD_A_NN: begin
        rk = KIND_BYTE; ra = s1_imm_r; acc_nxt = s1_load_r[7:0];
        pc_nxt = pc_r + 16'd3;
      end
      CMD_EI: begin
        ime_nxt = 1'b1; pc_nxt = pc_r + 16'd1;
      end
      CMD_CP_N: begin
        flags_nxt = cp_flags; pc_nxt = pc_r + 16'd2;
      end
      CMD_RST20, CMD_RST28, CMD_RST30, CMD_RST38: begin
        sp_nxt = sp_r - 16'd2;
        wk = KIND_WORD; wa = sp_r - 16'd2; wd = pc_r + 16'd1;
        // Vector is 0x20 plus eight times bits 4:3 of the opcode.
        pc_nxt = RST_BASE | {11'd0, s1_cmd_r[4:3], 3'b000};
      end
      default: begin
        ill = 1'b1;
      end
    endcase

    res_nxt.write_kind = wk;
    res_nxt.write_addr = wa;
    res_nxt.write_data = wd;
    res_nxt.read_kind  = rk;
    res_nxt.read_addr  = ra;
    res_nxt.pc         = pc_nxt;
    res_nxt.sp         = sp_nxt;
    res_nxt.acc        = acc_nxt;
    res_nxt.flags      = flags_nxt;
    res_nxt.hl         = hl_nxt;
    res_nxt.ime        = ime_nxt;
    res_nxt.illegal    = ill;
  end

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= 8'h00;
      flags_r     <= 4'h0;
      hl_r        <= 16'h0000;
      sp_r        <= 16'h0000;
      pc_r        <= 16'h0000;
      ime_r       <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (exec_go) begin
        s1_valid_r <= 1'b0;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      if (exec_go) begin
        acc_r   <= acc_nxt;
        flags_r <= flags_nxt;
        hl_r    <= hl_nxt;
        sp_r    <= sp_nxt;
        pc_r    <= pc_nxt;
        ime_r   <= ime_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r  <= in_cmd;
      s1_imm_r  <= in_imm_bytes;
      s1_load_r <= in_load_data;
      s1_c_r    <= in_reg_c;
    end
    if (exec_go) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_write_kind = res_r.write_kind;
  assign out_write_addr = res_r.write_addr;
  assign out_write_data = res_r.write_data;
  assign out_read_kind  = res_r.read_kind;
  assign out_read_addr  = res_r.read_addr;
  assign out_pc         = res_r.pc;
  assign out_sp         = res_r.sp;
  assign out_acc        = res_r.acc;
  assign out_flags      = {res_r.flags, 4'h0};
  assign out_hl         = res_r.hl;
  assign out_ime        = res_r.ime;
  assign out_illegal    = res_r.illegal;

  // An unused opcode reports no memory traffic.
  a_illegal_no_access: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_illegal |-> out_write_kind == KIND_NONE && out_read_kind == KIND_NONE)
    else $error("illegal opcode reported a memory access");

  // No write means zero address and data.
  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_kind == KIND_NONE |-> out_write_addr == 16'h0000
                                               && out_write_data == 16'h0000)
    else $error("write address or data nonzero without a write");

  // The input side only stalls while a word waits in the input stage.
  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with an empty input stage");

  // A word that executes while the output is held cannot happen; the check sees it as a rise of out_illegal.
  a_exec_after_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> !$rose(out_illegal) || $past(out_free))
    else $error("result register reloaded while stalled");

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the E0..FF opcode execute unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ce0ff_pkg::*;

  // Opcodes that the unit must flag as unused, one near each end of the range.
  localparam cmd_t CMD_UNUSED_LO = 5'h03;
  localparam cmd_t CMD_UNUSED_HI = 5'h1D;

  // Slowest legal run: every word waits out a full sender gap and a full
  // receiver burst, plus the long hold. The limit sits several times above it.
  localparam int CYCLE_LIMIT = 250000;
  localparam int DRAIN_CYCLES = 8;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  cmd_t        in_cmd = '0;
  logic [15:0] in_imm_bytes = '0;
  logic [15:0] in_load_data = '0;
  logic [7:0]  in_reg_c = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  kind_t       out_write_kind;
  logic [15:0] out_write_addr;
  logic [15:0] out_write_data;
  kind_t       out_read_kind;
  logic [15:0] out_read_addr;
  logic [15:0] out_pc;
  logic [15:0] out_sp;
  logic [7:0]  out_acc;
  logic [7:0]  out_flags;
  logic [15:0] out_hl;
  logic        out_ime;
  logic        out_illegal;

  cpu_opcode_e0_ff_execute_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_imm_bytes   (in_imm_bytes),
    .in_load_data   (in_load_data),
    .in_reg_c       (in_reg_c),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_write_kind (out_write_kind),
    .out_write_addr (out_write_addr),
    .out_write_data (out_write_data),
    .out_read_kind  (out_read_kind),
    .out_read_addr  (out_read_addr),
    .out_pc         (out_pc),
    .out_sp         (out_sp),
    .out_acc        (out_acc),
    .out_flags      (out_flags),
    .out_hl         (out_hl),
    .out_ime        (out_ime),
    .out_illegal    (out_illegal)
  );

  // Shadow copy of the CPU registers that the unit owns. It advances once per
  // accepted word, in acceptance order, exactly as the unit must.
  logic [7:0]  acc_q;
  logic [3:0]  flags_q;
  logic [15:0] hl_q;
  logic [15:0] sp_q;
  logic [15:0] pc_q;
  logic        ime_q;

  // Predicted result words, oldest first.
  res_t pending_execs[$];

  int mismatch_count = 0;
  int cycle_count = 0;

  // Idling controls. The test tasks switch these; the receiver reads them
  // every cycle and the sender reads tx_idle_en before each word.
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // SP plus a sign-extended offset byte. H and C come from the unsigned
  // carries out of bits 3 and 7; Z and N are always clear.
  function automatic logic [15:0] sp_plus_offset(input logic [7:0] off,
                                                 output logic [3:0] fl);
    logic [4:0] nib_sum;
    logic [8:0] byte_sum;
    nib_sum  = {1'b0, sp_q[3:0]} + {1'b0, off[3:0]};
    byte_sum = {1'b0, sp_q[7:0]} + {1'b0, off};
    fl = (nib_sum[4] ? FLAG_H : 4'h0) | (byte_sum[8] ? FLAG_C : 4'h0);
    return sp_q + {{8{off[7]}}, off};
  endfunction

  // Executes one instruction on the shadow registers and returns the result
  // word the unit should produce for it.
  function automatic res_t exec_opcode(input cmd_t cmd, input logic [15:0] imm,
                                       input logic [15:0] ld, input logic [7:0] c);
    res_t r;
    logic [7:0]  n;
    logic [15:0] pc_n;
    logic [3:0]  fl;
    r = '0;
    n = imm[7:0];
    pc_n = pc_q;
    case (cmd)
      CMD_LDH_N_A: begin
        r.write_kind = KIND_BYTE;
        r.write_addr = {HIGH_PAGE, n};
        r.write_data = {8'h00, acc_q};
        pc_n = pc_q + 16'd2;
      end
      CMD_POP_HL: begin
        r.read_kind = KIND_WORD;
        r.read_addr = sp_q;
        hl_q = ld;
        sp_q = sp_q + 16'd2;
        pc_n = pc_q + 16'd1;
      end
      CMD_LD_C_A: begin
        r.write_kind = KIND_BYTE;
        r.write_addr = {HIGH_PAGE, c};
        r.write_data = {8'h00, acc_q};
        pc_n = pc_q + 16'd1;
      end
      CMD_PUSH_HL: begin
        sp_q = sp_q - 16'd2;
        r.write_kind = KIND_WORD;
        r.write_addr = sp_q;
        r.write_data = hl_q;
        pc_n = pc_q + 16'd1;
      end
      CMD_AND_N: begin
        acc_q = acc_q & n;
        flags_q = (acc_q == 8'h00 ? FLAG_Z : 4'h0) | FLAG_H;
        pc_n = pc_q + 16'd2;
      end
      CMD_ADD_SP: begin
        sp_q = sp_plus_offset(n, fl);
        flags_q = fl;
        pc_n = pc_q + 16'd2;
      end
      CMD_JP_HL: pc_n = hl_q;
      CMD_LD_NN_A: begin
        r.write_kind = KIND_BYTE;
        r.write_addr = imm;
        r.write_data = {8'h00, acc_q};
        pc_n = pc_q + 16'd3;
      end
      CMD_XOR_N: begin
        acc_q = acc_q ^ n;
        flags_q = (acc_q == 8'h00) ? FLAG_Z : 4'h0;
        pc_n = pc_q + 16'd2;
      end
      CMD_LDH_A_N: begin
        r.read_kind = KIND_BYTE;
        r.read_addr = {HIGH_PAGE, n};
        acc_q = ld[7:0];
        pc_n = pc_q + 16'd2;
      end
      CMD_POP_AF: begin
        r.read_kind = KIND_WORD;
        r.read_addr = sp_q;
        flags_q = ld[7:4];
        acc_q = ld[15:8];
        sp_q = sp_q + 16'd2;
        pc_n = pc_q + 16'd1;
      end
      CMD_LD_A_C: begin
        r.read_kind = KIND_BYTE;
        r.read_addr = {HIGH_PAGE, c};
        acc_q = ld[7:0];
        pc_n = pc_q + 16'd1;
      end
      CMD_DI: begin
        ime_q = 1'b0;
        pc_n = pc_q + 16'd1;
      end
      CMD_PUSH_AF: begin
        sp_q = sp_q - 16'd2;
        r.write_kind = KIND_WORD;
        r.write_addr = sp_q;
        r.write_data = {acc_q, flags_q, 4'h0};
        pc_n = pc_q + 16'd1;
      end
      CMD_OR_N: begin
        acc_q = acc_q | n;
        flags_q = (acc_q == 8'h00) ? FLAG_Z : 4'h0;
        pc_n = pc_q + 16'd2;
      end
      CMD_LD_HL_SP: begin
        hl_q = sp_plus_offset(n, fl);
        flags_q = fl;
        pc_n = pc_q + 16'd2;
      end
      CMD_LD_SP_HL: begin
        sp_q = hl_q;
        pc_n = pc_q + 16'd1;
      end
      CMD_LD_A_NN: begin
        r.read_kind = KIND_BYTE;
        r.read_addr = imm;
        acc_q = ld[7:0];
        pc_n = pc_q + 16'd3;
      end
      CMD_EI: begin
        ime_q = 1'b1;
        pc_n = pc_q + 16'd1;
      end
      CMD_CP_N: begin
        fl = FLAG_N;
        if (acc_q == n) fl = fl | FLAG_Z;
        if (n[3:0] > acc_q[3:0]) fl = fl | FLAG_H;
        if (n > acc_q) fl = fl | FLAG_C;
        flags_q = fl;
        pc_n = pc_q + 16'd2;
      end
      CMD_RST20, CMD_RST28, CMD_RST30, CMD_RST38: begin
        // The return address is the byte after the RST opcode; the vector
        // comes from opcode bits 4..3.
        sp_q = sp_q - 16'd2;
        r.write_kind = KIND_WORD;
        r.write_addr = sp_q;
        r.write_data = pc_q + 16'd1;
        pc_n = RST_BASE + {11'b0, cmd[4:3], 3'b000};
      end
      default: r.illegal = 1'b1;
    endcase
    pc_q = pc_n;
    r.pc    = pc_q;
    r.sp    = sp_q;
    r.acc   = acc_q;
    r.flags = flags_q;
    r.hl    = hl_q;
    r.ime   = ime_q;
    return r;
  endfunction

  function automatic void check_field(input string what, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t ns: %s expected %h actual %h", $time, what, want, got);
    end
  endfunction

  // Scoreboard. Everything is sampled at the rising edge, before the unit's
  // registers move. The output side is checked before the input side is
  // predicted, so the queue sees a fixed order within one edge.
  always @(posedge clk) begin : scoreboard
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_execs.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: result word expected none, actual pc %h", $time, out_pc);
      end else begin
        want = pending_execs.pop_front();
        check_field("write_kind", 16'(want.write_kind), 16'(out_write_kind));
        check_field("write_addr", want.write_addr, out_write_addr);
        check_field("write_data", want.write_data, out_write_data);
        check_field("read_kind",  16'(want.read_kind), 16'(out_read_kind));
        check_field("read_addr",  want.read_addr,  out_read_addr);
        check_field("pc",         want.pc,         out_pc);
        check_field("sp",         want.sp,         out_sp);
        check_field("acc",        16'(want.acc),   16'(out_acc));
        check_field("flags",      16'({want.flags, 4'h0}), 16'(out_flags));
        check_field("hl",         want.hl,         out_hl);
        check_field("ime",        16'(want.ime),   16'(out_ime));
        check_field("illegal",    16'(want.illegal), 16'(out_illegal));
      end
    end
    if (rst_n && in_valid && !in_stall)
      pending_execs.push_back(exec_opcode(in_cmd, in_imm_bytes, in_load_data, in_reg_c));
  end

  // Receiver. A long hold requested by a test wins over everything else;
  // otherwise stall bursts start at random while idling is on.
  initial begin : receiver
    int unsigned burst_left;
    burst_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (rx_idle_en && burst_left > 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(0, 18);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top NOT OK");
    $finish;
  end

  // Offers one word, starting at a falling edge, and returns at the falling
  // edge after it was taken. Valid stays high between back-to-back words and
  // only drops for an idle gap, so it never toggles twice in one step.
  task automatic send_word(input cmd_t cmd, input logic [15:0] imm,
                           input logic [15:0] ld, input logic [7:0] c);
    int unsigned gap;
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_imm_bytes <= imm;
    in_load_data <= ld;
    in_reg_c     <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // A random instruction. Every opcode, unused ones included, is equally
  // likely. The operand is sometimes tied to the current accumulator so that
  // XOR and CP reach a zero result, and the data fields sometimes sit at
  // their extremes.
  task automatic send_random_word();
    cmd_t        cmd;
    logic [15:0] imm;
    logic [15:0] ld;
    logic [7:0]  c;
    cmd = cmd_t'($urandom_range(0, 31));
    imm = 16'($urandom());
    ld  = 16'($urandom());
    c   = 8'($urandom());
    case ($urandom_range(0, 11))
      0: imm[7:0] = acc_q;
      1: imm[7:0] = 8'h00;
      2: imm = 16'hFFFF;
      3: ld = 16'h0000;
      4: ld = 16'hFFFF;
      5: c = 8'hFF;
      default: ;
    endcase
    send_word(cmd, imm, ld, c);
  endtask

  task automatic wait_drained();
    while (pending_execs.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Walks through every operation with hand-picked operands: SP wrapping
  // through zero on PUSH and POP, the dropped low flag nibble on POP AF,
  // PC wrapping after JP (HL), a zero AND and OR, a nonzero XOR, CP with
  // borrow, half borrow and neither, signed SP offset carry cases, all
  // four RST vectors, IME set and cleared, and an unused opcode at each end.
  task automatic test_directed();
    send_word(CMD_PUSH_HL,  16'h0000, 16'h0000, 8'h00);
    send_word(CMD_POP_AF,   16'h0000, 16'hFFFF, 8'h00);
    send_word(CMD_PUSH_AF,  16'h0000, 16'h0000, 8'h00);
    send_word(CMD_POP_HL,   16'h0000, 16'hFFFF, 8'h00);
    send_word(CMD_JP_HL,    16'h0000, 16'h0000, 8'h00);
    send_word(CMD_LD_A_NN,  16'hFFFF, 16'h00FF, 8'h00);
    send_word(CMD_LD_NN_A,  16'h0000, 16'h0000, 8'h00);
    send_word(CMD_LDH_N_A,  16'h00FF, 16'h0000, 8'h00);
    send_word(CMD_LD_C_A,   16'h0000, 16'h0000, 8'hFF);
    send_word(CMD_LD_A_C,   16'hFFFF, 16'h1200, 8'h00);
    send_word(CMD_LDH_A_N,  16'h0000, 16'hFF80, 8'h00);
    send_word(CMD_AND_N,    16'h007F, 16'h0000, 8'h00);
    send_word(CMD_OR_N,     16'hFF00, 16'h0000, 8'h00);
    send_word(CMD_XOR_N,    16'h00FF, 16'h0000, 8'h00);
    send_word(CMD_CP_N,     16'h00FF, 16'h0000, 8'h00);
    send_word(CMD_XOR_N,    16'h00EF, 16'h0000, 8'h00);
    send_word(CMD_CP_N,     16'h0001, 16'h0000, 8'h00);
    send_word(CMD_CP_N,     16'h0020, 16'h0000, 8'h00);
    send_word(CMD_LD_SP_HL, 16'h0000, 16'h0000, 8'h00);
    send_word(CMD_ADD_SP,   16'h0001, 16'h0000, 8'h00);
    send_word(CMD_ADD_SP,   16'h0080, 16'h0000, 8'h00);
    send_word(CMD_LD_HL_SP, 16'h007F, 16'h0000, 8'h00);
    send_word(CMD_LD_HL_SP, 16'h00FF, 16'h0000, 8'h00);
    send_word(CMD_RST20,    16'h0000, 16'h0000, 8'h00);
    send_word(CMD_RST28,    16'h0000, 16'h0000, 8'h00);
    send_word(CMD_RST30,    16'h0000, 16'h0000, 8'h00);
    send_word(CMD_RST38,    16'h0000, 16'h0000, 8'h00);
    send_word(CMD_EI,       16'h0000, 16'h0000, 8'h00);
    send_word(CMD_DI,       16'h0000, 16'h0000, 8'h00);
    send_word(CMD_UNUSED_LO, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_word(CMD_UNUSED_HI, 16'h0000, 16'h0000, 8'h00);
  endtask

  task automatic test_random(input int count);
    repeat (count) send_random_word();
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering words back to back, so the unit fills and raises in_stall.
  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    hold_left = 80;
    repeat (30) send_random_word();
    tx_idle_en = 1'b1;
  endtask

  // Groups of words with the sender waiting for every result in between, so
  // the unit runs from empty again each time.
  task automatic test_drain_pause();
    repeat (4) begin
      repeat (10) send_random_word();
      in_valid <= 1'b0;
      wait_drained();
    end
  endtask

  // Full-rate streaming with no idling on either side.
  task automatic test_streaming(input int count);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (count) send_random_word();
  endtask

  initial begin : main
    acc_q = '0;
    flags_q = '0;
    hl_q = '0;
    sp_q = '0;
    pc_q = '0;
    ime_q = 1'b0;

    // Synchronous reset, held and then released at a falling edge.
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random(220);
    test_backpressure();
    test_drain_pause();
    test_random(150);
    test_streaming(80);

    // All words have been taken; let the pipeline empty and then keep watching
    // for any stray result.
    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_execs.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

[filelist.f]
src/ce0ff_pkg.sv
src/cpu_opcode_e0_ff_execute_unit.sv
sim/tb_top.sv
